### hdl/fwer_pkg.sv
// shared types, constants and the top-window table for the fixed-window recoder
// no dependencies
`default_nettype none

package fwer_pkg;

  localparam int FieldBits = 31;  // width of value and digit fields
  localparam int WinBits   = 5;   // width of window width register
  localparam int PosBits   = 5;   // width of digit position field

  localparam logic [WinBits-1:0] WindowReset = WinBits'(2);

  typedef enum logic {
    FWER_IDLE,
    FWER_SCAN
  } fwer_state_e;

  // result of one pass of the shared shift/mask unit
  typedef struct packed {
    logic [FieldBits-1:0] digit;
    logic [FieldBits-1:0] rem;
    logic                 nonzero;
  } fwer_step_t;

  // index of the highest window whose low bit lies inside the field,
  // i.e. floor(30 / w) for a window width w of 1..31
  function automatic logic [PosBits-1:0] top_index(input logic [WinBits-1:0] w);
    logic [PosBits-1:0] idx;
    unique case (w)
      5'd0, 5'd1: idx = 5'd30;
      5'd2:       idx = 5'd15;
      5'd3:       idx = 5'd10;
      5'd4:       idx = 5'd7;
      5'd5:       idx = 5'd6;
      5'd6:       idx = 5'd5;
      5'd7:       idx = 5'd4;
      5'd8, 5'd9, 5'd10: idx = 5'd3;
      5'd11, 5'd12, 5'd13, 5'd14, 5'd15: idx = 5'd2;
      5'd31:      idx = 5'd0;
      default:    idx = 5'd1;
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

### hdl/fixed_window_exponent_recoding_core.sv
// fixed-window exponent recoding core: top level with sequencer and result register
// depends on fwer_pkg and fwer_window_unit
`default_nettype none

// Splits a positive integer into its base 2^w digits and emits the nonzero
// ones, most significant first, one item per digit with its window position
// and a last flag on the final digit. A window width of zero acts as one.
// The accept cycle loads the value and the top window index; after that
// the sequencer visits one window per cycle while the result register is
// empty or being drained by out_ready_i, from the top window down to the
// lowest nonzero digit. The single barrel shift/mask unit handles one
// window per cycle. A value that is zero (after masking to VALUE_BITS)
// produces no item and leaves the block ready in the next cycle.
// The input side is not ready while a value is being scanned; a finished
// digit may still sit in the result register when the next value is taken.
module fixed_window_exponent_recoding_core
  import fwer_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [WinBits-1:0]   cfg_window_bits_i,
  // input item channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [FieldBits-1:0] value_i,
  // result item channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [FieldBits-1:0]      digit_o,
  output logic [PosBits-1:0]        position_o,
  output logic                      last_o
);

  // bits of the value actually used
  localparam int UsedBits = (VALUE_BITS < FieldBits) ? VALUE_BITS : FieldBits;

  // configuration register
  logic [WinBits-1:0] window_q;
  logic [WinBits-1:0] win_eff;

  // sequencer state
  fwer_state_e          state_q, state_d;
  logic [UsedBits-1:0]  rem_q;
  logic [PosBits-1:0]   idx_q;
  logic [PosBits-1:0]   shift_q;

  // result register
  logic                 out_valid_q;
  logic [FieldBits-1:0] digit_q;
  logic [PosBits-1:0]   pos_q;
  logic                 last_q;

  // control
  logic                 in_fire;
  logic                 load_nz;
  logic                 step_en;
  logic                 scan_done;
  logic [UsedBits-1:0]  value_used;
  logic [PosBits-1:0]   top_idx;
  logic [2*WinBits-1:0] top_shift;
  fwer_step_t           step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_window_bits_i;
    end
  end

  // zero width behaves as one bit
  assign win_eff = (window_q == '0) ? WinBits'(1) : window_q;

  assign value_used = value_i[UsedBits-1:0];
  assign top_idx    = top_index(win_eff);
  assign top_shift  = (2*WinBits)'(top_idx) * (2*WinBits)'(win_eff);

  // shared shift/mask unit
  fwer_window_unit u_unit (
    .rem_i    (FieldBits'(rem_q)),
    .shift_i  (shift_q),
    .window_i (win_eff),
    .step_o   (step)
  );

  // scan ends when nothing is left or the bottom window was visited
  assign scan_done = (step.rem[UsedBits-1:0] == '0) || (idx_q == '0);

  // sequencer outputs
  always_comb begin
    in_ready_o = (state_q == FWER_IDLE);
    step_en    = (state_q == FWER_SCAN) && (!out_valid_q || out_ready_i);
    in_fire    = in_valid_i && in_ready_o;
    load_nz    = in_fire && (value_used != '0);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FWER_IDLE: begin
        if (load_nz) begin
          state_d = FWER_SCAN;
        end
      end
      FWER_SCAN: begin
        if (step_en && scan_done) begin
          state_d = FWER_IDLE;
        end
      end
      default: state_d = FWER_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FWER_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // remainder, window index and bit offset of the current window
  always_ff @(posedge clk_i) begin
    if (load_nz) begin
      rem_q   <= value_used;
      idx_q   <= top_idx;
      shift_q <= top_shift[PosBits-1:0];
    end else if (step_en) begin
      rem_q   <= step.rem[UsedBits-1:0];
      idx_q   <= idx_q - PosBits'(1);
      shift_q <= shift_q - win_eff;
    end
  end

  // result register: filled on a nonzero digit, drained by out_ready_i
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en && step.nonzero) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && step.nonzero) begin
      digit_q <= step.digit;
      pos_q   <= idx_q;
      last_q  <= (step.rem[UsedBits-1:0] == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign digit_o     = digit_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

  // a scan always has something left to emit
  a_scan_rem_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FWER_SCAN) |-> (rem_q != '0))
    else $error("scan running with empty remainder");

  // a delivered digit is never zero
  a_digit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_o != '0))
    else $error("zero digit emitted");

  // a nonzero value starts a scan
  a_load_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_nz |=> (state_q == FWER_SCAN))
    else $error("nonzero value did not start a scan");

  // visiting the bottom window ends the scan
  a_bottom_ends_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && (idx_q == '0)) |=> (state_q == FWER_IDLE))
    else $error("scan continued past the bottom window");

  // the final digit of a scan carries the last flag
  a_last_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && step.nonzero && (step.rem[UsedBits-1:0] == '0)) |=> (out_valid_o && last_o))
    else $error("final digit without last flag");

endmodule

`default_nettype wire

### hdl/fwer_window_unit.sv
// shared shift/mask unit: extracts one window digit and clears it from the remainder
// depends on fwer_pkg
`default_nettype none

module fwer_window_unit
  import fwer_pkg::*;
(
  input  wire logic [FieldBits-1:0] rem_i,
  input  wire logic [PosBits-1:0]   shift_i,
  input  wire logic [WinBits-1:0]   window_i,
  output fwer_step_t                step_o
);

  logic [FieldBits-1:0] dmask;
  logic [FieldBits-1:0] shifted;

  // window of all ones when w reaches the field width
  assign dmask   = ~({FieldBits{1'b1}} << window_i);
  assign shifted = rem_i >> shift_i;

  always_comb begin
    step_o.digit   = shifted & dmask;
    step_o.rem     = rem_i & ~(dmask << shift_i);
    step_o.nonzero = |(shifted & dmask);
  end

endmodule

`default_nettype wire

### verif/tb_fixed_window_exponent_recoding_core.sv
// testbench for fixed_window_exponent_recoding_core: self-checking run of directed and random items
// depends on fwer_pkg and the core; digit predictor and expected-digit queue live in a small class
`default_nettype none

module tb_fixed_window_exponent_recoding_core
  import fwer_pkg::*;
;

  localparam int ValueBits      = 31;
  localparam int NumPhases      = 12;  // one window width per phase
  localparam int DirectedPhases = 5;   // phases that open with the directed values
  localparam int RandomPerPhase = 36;  // random items per phase, about 460 items in total
  localparam int SettleCycles   = 40;  // longest scan plus margin, before a register write
  localparam int IdleMax        = 15;  // longest idle gap drawn on either side

  localparam logic [FieldBits-1:0] ValueMax = '1;

  // one emitted digit as the block should present it
  typedef struct {
    logic [FieldBits-1:0] digit;
    logic [PosBits-1:0]   position;
    logic                 last;
  } window_digit_t;

  // keeps the window width and the queue of digits still owed by the block
  class window_digit_board;
    logic [WinBits-1:0] window_width;
    window_digit_t      expected_digits[$];
    int                 errors;

    function new();
      window_width = WindowReset;
      errors       = 0;
    endfunction

    function void set_window(logic [WinBits-1:0] w);
      window_width = w;
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    // split an accepted value into its nonzero base 2^w digits, top window first
    function void note_value(logic [FieldBits-1:0] value);
      int unsigned          w;
      int unsigned          shift;
      logic [63:0]          wide_mask;
      logic [FieldBits-1:0] dmask;
      logic [FieldBits-1:0] rem;
      logic [FieldBits-1:0] d;
      window_digit_t        rec;
      w         = (window_width == '0) ? 1 : int'(window_width);  // width zero acts as one
      wide_mask = (64'd1 << w) - 64'd1;
      dmask     = wide_mask[FieldBits-1:0];
      rem       = value;
      for (int j = FieldBits - 1; j >= 0; j--) begin
        shift = j * w;
        if (shift >= FieldBits) continue;  // window starts above the field
        d = (rem >> shift) & dmask;
        if (d == '0) continue;             // zero digits are skipped
        rem          &= ~(dmask << shift);
        rec.digit     = d;
        rec.position  = PosBits'(j);
        rec.last      = (rem == '0);
        expected_digits.push_back(rec);
        if (rem == '0) break;
      end
    endfunction

    task report_mismatch(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    task check_digit(logic [FieldBits-1:0] digit, logic [PosBits-1:0] position, logic last);
      window_digit_t exp_d;
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("digit %0h pos %0d last %0b with nothing pending",
                                  digit, position, last));
      end else begin
        exp_d = expected_digits.pop_front();
        if (digit !== exp_d.digit)
          report_mismatch($sformatf("digit %0h, wanted %0h", digit, exp_d.digit));
        if (position !== exp_d.position)
          report_mismatch($sformatf("position %0d, wanted %0d", position, exp_d.position));
        if (last !== exp_d.last)
          report_mismatch($sformatf("last %0b, wanted %0b", last, exp_d.last));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [WinBits-1:0]   cfg_window_bits_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [FieldBits-1:0] value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [FieldBits-1:0] digit_o;
  logic [PosBits-1:0]   position_o;
  logic                 last_o;

  window_digit_board board;

  fixed_window_exponent_recoding_core #(
    .VALUE_BITS(ValueBits)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_window_bits_i(cfg_window_bits_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digit_o          (digit_o),
    .position_o       (position_o),
    .last_o           (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // safety net against a hung handshake
  initial begin
    #15_000_000;
    $display("fixed_window_exponent_recoding_core: mismatch");
    $finish;
  end

  // mix of dense, sparse, tiny and extreme values, with an occasional zero
  function automatic logic [FieldBits-1:0] random_value();
    logic [FieldBits-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = FieldBits'($urandom);
      3:       v = FieldBits'($urandom_range(1, 255));
      4:       v = FieldBits'(1) << $urandom_range(0, FieldBits - 1);
      5:       v = FieldBits'($urandom & $urandom & $urandom);
      6:       v = ValueMax << $urandom_range(0, FieldBits - 1);
      7:       v = ValueMax >> $urandom_range(0, FieldBits - 1);
      8:       v = FieldBits'($urandom | $urandom);
      default: v = ($urandom_range(0, 1) == 0) ? '0 : ValueMax;
    endcase
    return v;
  endfunction

  // present one item after a random gap, return at the accepting edge
  // valid stays high on return so back-to-back items need no drop
  task send_value(logic [FieldBits-1:0] v);
    int gap;
    gap = $urandom_range(0, IdleMax);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    board.note_value(v);
  endtask

  // stop sending, wait for every owed digit, then let the scan wind down
  task finish_phase();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write, only called with the block idle
  task write_window(logic [WinBits-1:0] w);
    cfg_valid_i       <= 1'b1;
    cfg_window_bits_i <= w;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    board.set_window(w);
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stall before each item, ready held high when no stall
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, IdleMax);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      board.check_digit(digit_o, position_o, last_o);
    end
  end

  // main sequence
  initial begin
    logic [WinBits-1:0]   widths[NumPhases];
    logic [FieldBits-1:0] directed[5];
    board             = new();
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_window_bits_i = '0;
    in_valid_i        = 1'b0;
    value_i           = '0;

    // reset width first, then the extremes, zero width, widths 16 and 30, then random widths
    widths[0] = WindowReset;
    widths[1] = WinBits'(1);
    widths[2] = WinBits'(31);
    widths[3] = WinBits'(0);
    widths[4] = WinBits'(16);
    widths[5] = WinBits'(30);
    for (int p = 6; p < NumPhases; p++) widths[p] = WinBits'($urandom_range(0, 31));

    // smallest, largest, zero (no digits), far-apart digits, alternating bits
    directed[0] = FieldBits'(1);
    directed[1] = ValueMax;
    directed[2] = '0;
    directed[3] = FieldBits'(32'h4000_0001);
    directed[4] = FieldBits'(32'h2AAA_AAAA);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      // sender holds off until the block has drained before each write
      if (p > 0) begin
        finish_phase();
        write_window(widths[p]);
      end
      if (p < DirectedPhases)
        foreach (directed[k]) send_value(directed[k]);
      repeat (RandomPerPhase) send_value(random_value());
    end
    finish_phase();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("fixed_window_exponent_recoding_core: match");
    end else begin
      $display("fixed_window_exponent_recoding_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
